>>> hw/rtl/gamepad_input_report_builder_core_macros.svh
// Assertion helpers shared by the RTL
`ifndef GAMEPAD_INPUT_REPORT_BUILDER_CORE_MACROS_SVH
`define GAMEPAD_INPUT_REPORT_BUILDER_CORE_MACROS_SVH

// same-cycle implication, clocked on clock and off while reset is high
`define GPIRB_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GPIRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/gpirb_pkg.sv
package gpirb_pkg;

   localparam int REQ_DATA_BITS = 184;
   localparam int RSP_DATA_BITS = 144;

   // input item, last declared field (left_stick_x) in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic signed [15:0] second_finger_dy;
      logic signed [15:0] second_finger_dx;
      logic signed [15:0] first_finger_dy;
      logic signed [15:0] first_finger_dx;
      logic [17:0]        button_bits;
      logic signed [15:0] right_trigger;
      logic signed [15:0] left_trigger;
      logic signed [15:0] right_stick_y;
      logic signed [15:0] right_stick_x;
      logic signed [15:0] left_stick_y;
      logic signed [15:0] left_stick_x;
   } req_item_type;

   // result item, last declared field (sticks_packed) in the lowest bits
   typedef struct packed {
      logic [23:0] second_finger_xy;
      logic [7:0]  second_finger_id;
      logic [23:0] first_finger_xy;
      logic [7:0]  first_finger_id;
      logic [7:0]  touch_count;
      logic [5:0]  report_count;
      logic [13:0] button_word;
      logic [3:0]  hat_code;
      logic [15:0] triggers_packed;
      logic [31:0] sticks_packed;
   } rsp_item_type;

   // register indexes
   localparam logic CSR_PAD_MAX_X = 1'b0;
   localparam logic CSR_PAD_MAX_Y = 1'b1;

   localparam logic [11:0] PAD_MAX_X_RESET = 12'd1919;
   localparam logic [11:0] PAD_MAX_Y_RESET = 12'd942;

   localparam logic [5:0] SEQ_RESET    = 6'd63;
   localparam logic [7:0] TOUCH_STEP   = 8'd4;
   localparam logic [7:0] ID_ABSENT    = 8'h80;

   localparam logic [3:0] HAT_UP         = 4'd0;
   localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
   localparam logic [3:0] HAT_RIGHT      = 4'd2;
   localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
   localparam logic [3:0] HAT_DOWN       = 4'd4;
   localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
   localparam logic [3:0] HAT_LEFT       = 4'd6;
   localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
   localparam logic [3:0] HAT_NONE       = 4'd8;

   // clamp(v + 128, 0, 255) for a stick axis
   function automatic logic [7:0] stick_byte(input logic signed [15:0] v);
      logic signed [16:0] s;
      s = 17'(v) + 17'sd128;
      if (s[16])
         return 8'd0;
      else if (s > 17'sd255)
         return 8'hFF;
      else
         return s[7:0];
   endfunction

   // clamp(v, 0, 255) for a trigger
   function automatic logic [7:0] trigger_byte(input logic signed [15:0] v);
      if (v[15])
         return 8'd0;
      else if (v > 16'sd255)
         return 8'hFF;
      else
         return v[7:0];
   endfunction

endpackage

>>> hw/rtl/gamepad_input_report_builder_core.sv
// A result is written into the result buffer when its item is accepted.
// Throughput: one item per cycle until both buffer slots hold results; the two-slot
// result buffer keeps req_tready high while one finished result waits on the rsp side.
// Reset (synchronous, active high) loads pad maxima 1919/942, report counter 63,
// touch counter 0, both fingers absent at position 0, and empties the buffer.
`include "gamepad_input_report_builder_core_macros.svh"

module gamepad_input_report_builder_core
   import gpirb_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic                     csr_index,
   input  logic [11:0]              csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // left_stick_x, left_stick_y, right_stick_x, right_stick_y, left_trigger,
   // right_trigger, button_bits[18], first_finger_dx, first_finger_dy,
   // second_finger_dx, second_finger_dy, zero pad[6]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // sticks_packed[32], triggers_packed[16], hat_code[4], button_word[14],
   // report_count[6], touch_count[8], first_finger_id[8], first_finger_xy[24],
   // second_finger_id[8], second_finger_xy[24]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int PackBits = 2 * COORD_BITS;

   logic [11:0]         max_x_ff, max_y_ff;
   logic [5:0]          seq_ff, seq_in;
   logic [7:0]          touch_ff, touch_in;
   logic [7:0]          id_ff [2];
   logic [7:0]          id_in [2];
   logic [23:0]         pos_ff [2];
   logic [23:0]         pos_in [2];
   logic [1:0]          cnt_ff, cnt_in;
   rsp_item_type        slot0_ff, slot0_in, slot1_ff, slot1_in;
   req_item_type        req;
   rsp_item_type        res;
   logic                push, pop;
   logic [1:0]          present;
   logic signed [15:0]  dx [2];
   logic signed [15:0]  dy [2];

   assign req        = req_item_type'(req_tdata);
   assign req_tready = (cnt_ff != 2'd2);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = slot0_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   assign present = req.button_bits[17:16];
   assign dx[0] = req.first_finger_dx;
   assign dy[0] = req.first_finger_dy;
   assign dx[1] = req.second_finger_dx;
   assign dy[1] = req.second_finger_dy;

   // finger tracking, two independent lanes
   always_comb begin
      logic [PackBits-1:0] rd    [2];
      logic [16:0]         bx    [2];
      logic [16:0]         by    [2];
      logic signed [17:0]  sx    [2];
      logic signed [17:0]  sy    [2];
      logic [11:0]         cx12  [2];
      logic [11:0]         cy12  [2];
      logic [PackBits-1:0] pk    [2];
      for (int n = 0; n < 2; n++) begin
         rd[n] = PackBits'(pos_ff[n]);
         if (id_ff[n][7]) begin
            bx[n] = 17'(max_x_ff[11:1]);
            by[n] = 17'(max_y_ff[11:1]);
         end else begin
            bx[n] = 17'(rd[n][COORD_BITS-1:0]);
            by[n] = 17'(rd[n][PackBits-1:COORD_BITS]);
         end
         sx[n] = $signed({1'b0, bx[n]}) + $signed({{2{dx[n][15]}}, dx[n]});
         sy[n] = $signed({1'b0, by[n]}) + $signed({{2{dy[n][15]}}, dy[n]});
         if (sx[n][17])
            cx12[n] = 12'd0;
         else if (sx[n][16:0] > {5'd0, max_x_ff})
            cx12[n] = max_x_ff;
         else
            cx12[n] = sx[n][11:0];
         if (sy[n][17])
            cy12[n] = 12'd0;
         else if (sy[n][16:0] > {5'd0, max_y_ff})
            cy12[n] = max_y_ff;
         else
            cy12[n] = sy[n][11:0];
         pk[n] = {COORD_BITS'(cy12[n]), COORD_BITS'(cx12[n])};
         if (!present[n]) begin
            id_in[n]  = id_ff[n] | ID_ABSENT;
            pos_in[n] = pos_ff[n];
         end else begin
            // a new touch advances the 7-bit id
            id_in[n]  = {1'b0, id_ff[n][6:0] + {6'd0, id_ff[n][7]}};
            pos_in[n] = 24'(pk[n]);
         end
      end
   end

   always_comb begin
      logic [17:0] b;
      b      = req.button_bits;
      seq_in = seq_ff + 6'd1;
      touch_in = (|present) ? touch_ff + TOUCH_STEP : touch_ff;

      res.sticks_packed   = {stick_byte(req.right_stick_y), stick_byte(req.right_stick_x),
                             stick_byte(req.left_stick_y), stick_byte(req.left_stick_x)};
      res.triggers_packed = {trigger_byte(req.right_trigger),
                             trigger_byte(req.left_trigger)};
      // right beats left, down beats up
      if (b[1])
         res.hat_code = b[2] ? HAT_DOWN_RIGHT : (b[0] ? HAT_UP_RIGHT : HAT_RIGHT);
      else if (b[3])
         res.hat_code = b[2] ? HAT_DOWN_LEFT : (b[0] ? HAT_UP_LEFT : HAT_LEFT);
      else if (b[2])
         res.hat_code = HAT_DOWN;
      else if (b[0])
         res.hat_code = HAT_UP;
      else
         res.hat_code = HAT_NONE;
      res.button_word      = {b[15:10], (req.right_trigger != 16'sd0),
                              (req.left_trigger != 16'sd0), b[9:8], b[7:4]};
      res.report_count     = seq_in;
      res.touch_count      = touch_in;
      res.first_finger_id  = id_in[0];
      res.first_finger_xy  = pos_in[0];
      res.second_finger_id = id_in[1];
      res.second_finger_xy = pos_in[1];
   end

   // result buffer: slot0 is the head, slot1 the skid entry
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (pop && !push) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end else if (push && !pop) begin
         if (cnt_ff == 2'd0)
            slot0_in = res;
         else
            slot1_in = res;
         cnt_in = cnt_ff + 2'd1;
      end else if (push && pop) begin
         slot0_in = res;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff   <= 2'd0;
         max_x_ff <= PAD_MAX_X_RESET;
         max_y_ff <= PAD_MAX_Y_RESET;
         seq_ff   <= SEQ_RESET;
         touch_ff <= 8'd0;
         for (int n = 0; n < 2; n++) begin
            id_ff[n]  <= ID_ABSENT;
            pos_ff[n] <= 24'd0;
         end
      end else begin
         cnt_ff <= cnt_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_PAD_MAX_X: max_x_ff <= csr_wdata;
               CSR_PAD_MAX_Y: max_y_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (push) begin
            seq_ff   <= seq_in;
            touch_ff <= touch_in;
            for (int n = 0; n < 2; n++) begin
               id_ff[n]  <= id_in[n];
               pos_ff[n] <= pos_in[n];
            end
         end
      end
   end

   `GPIRB_ASSERT_NEXT(a_fill_second_slot, push && !pop && cnt_ff == 2'd1, cnt_ff == 2'd2, "result buffer count did not reach two")
   `GPIRB_ASSERT_NEXT(a_seq_advance, push, seq_ff == 6'($past(seq_ff) + 6'd1), "report counter did not advance on an item")
   `GPIRB_ASSERT_NEXT(a_touch_hold, push && present == 2'b00, touch_ff == $past(touch_ff), "touch counter moved with no finger present")
   `GPIRB_ASSERT_NEXT(a_absent_id, push && !present[0], id_ff[0][7] && pos_ff[0] == $past(pos_ff[0]), "absent first finger not marked or position changed")

endmodule
